[design/canonical_line_key_top_assert.svh]
// Assertion macros shared by the canonical line key design.
`ifndef CANONICAL_LINE_KEY_TOP_ASSERT_SVH
`define CANONICAL_LINE_KEY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CLK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CLK_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CLK_ASSERT(lbl, prop, msg)
`define CLK_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[design/clk_pkg.sv]
// Package with constants and stage types of the canonical line key design.
`timescale 1ns / 1ps
package clk_pkg;
    localparam int MAX_SIDE = 64;
    localparam int COORD_W = 6;
    localparam int SIDE_W = 7;
    localparam int GCD_STEPS = 12;
    localparam int DIV_STEPS = COORD_W;
    localparam logic [SIDE_W-1:0] BOARD_SIDE_RESET = 7'd28;
    localparam logic REG_BOARD_SIDE = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               sa;
        logic               sb;
        logic [COORD_W-1:0] am;
        logic [COORD_W-1:0] bm;
        logic               oor;
    } t_ctx;

    typedef struct packed {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic [2:0]         k;
    } t_gcd;

    typedef struct packed {
        logic [COORD_W-1:0] g;
        logic [COORD_W-1:0] na;
        logic [COORD_W-1:0] nb;
        logic [COORD_W-1:0] ra;
        logic [COORD_W-1:0] rb;
    } t_div;
endpackage

[design/clk_gcd_step.sv]
// One registered step of the binary gcd of the two coefficient magnitudes.
`timescale 1ns / 1ps
module clk_gcd_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  clk_pkg::t_ctx i_ctx,
    input  clk_pkg::t_gcd i_gcd,
    output logic          o_valid,
    output clk_pkg::t_ctx o_ctx,
    output clk_pkg::t_gcd o_gcd
);
    import clk_pkg::*;

    t_gcd n_gcd;
    logic r_valid;
    t_ctx r_ctx;
    t_gcd r_gcd;

    always_comb begin
        n_gcd = i_gcd;
        if (i_gcd.u != '0 && i_gcd.v != '0) begin
            if (!i_gcd.u[0] && !i_gcd.v[0]) begin
                n_gcd.u = i_gcd.u >> 1;
                n_gcd.v = i_gcd.v >> 1;
                n_gcd.k = i_gcd.k + 3'd1;
            end else if (!i_gcd.u[0]) begin
                n_gcd.u = i_gcd.u >> 1;
            end else if (!i_gcd.v[0]) begin
                n_gcd.v = i_gcd.v >> 1;
            end else if (i_gcd.u >= i_gcd.v) begin
                n_gcd.u = (i_gcd.u - i_gcd.v) >> 1;
            end else begin
                n_gcd.v = (i_gcd.v - i_gcd.u) >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctx <= i_ctx;
            r_gcd <= n_gcd;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx = r_ctx;
    assign o_gcd = r_gcd;
endmodule

[design/clk_div_step.sv]
// One registered restoring division step for both coefficient quotients.
`timescale 1ns / 1ps
module clk_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  clk_pkg::t_ctx i_ctx,
    input  clk_pkg::t_div i_div,
    output logic          o_valid,
    output clk_pkg::t_ctx o_ctx,
    output clk_pkg::t_div o_div
);
    import clk_pkg::*;

    logic [COORD_W:0] part_a;
    logic [COORD_W:0] part_b;
    logic             ge_a;
    logic             ge_b;
    t_div             n_div;
    logic             r_valid;
    t_ctx             r_ctx;
    t_div             r_div;

    always_comb begin
        part_a = {i_div.ra, i_div.na[COORD_W-1]};
        part_b = {i_div.rb, i_div.nb[COORD_W-1]};
        ge_a = part_a >= {1'b0, i_div.g};
        ge_b = part_b >= {1'b0, i_div.g};
        n_div = i_div;
        n_div.na = {i_div.na[COORD_W-2:0], ge_a};
        n_div.nb = {i_div.nb[COORD_W-2:0], ge_b};
        n_div.ra = ge_a ? COORD_W'(part_a - {1'b0, i_div.g}) : COORD_W'(part_a);
        n_div.rb = ge_b ? COORD_W'(part_b - {1'b0, i_div.g}) : COORD_W'(part_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_ctx <= i_ctx;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctx = r_ctx;
    assign o_div = r_div;
endmodule

[design/canonical_line_key_top.sv]
// Throughput: one transfer per cycle while the output is not stalled; the gcd
// runs as 12 binary steps and the quotients as 6 restoring steps, each step a
// pipeline register stage. A stall at the output holds the whole pipeline in place.
// Reset is synchronous and active low; it empties the pipeline and sets the
// board side to 28.
`timescale 1ns / 1ps
`include "canonical_line_key_top_assert.svh"
module canonical_line_key_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_first_x,
    input  logic [5:0]  i_first_y,
    input  logic [5:0]  i_second_x,
    input  logic [5:0]  i_second_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [6:0]  o_coef_a,
    output logic signed [6:0]  o_coef_b,
    output logic signed [12:0] o_coef_c,
    output logic [26:0] o_packed_key,
    output logic        o_out_of_range
);
    import clk_pkg::*;

    logic [SIDE_W-1:0]        r_side;
    logic [SIDE_W-1:0]        side_eff;
    logic [COORD_W-1:0]       r_coord_off;
    logic [SIDE_W-1:0]        r_coord_span;
    logic [2*COORD_W-1:0]     r_const_off;
    logic [2*COORD_W:0]       r_const_span;
    logic                     en;

    logic signed [COORD_W:0]  diff_a;
    logic signed [COORD_W:0]  diff_b;
    t_ctx                     n_ctx;

    logic                     gv   [0:GCD_STEPS];
    t_ctx                     gctx [0:GCD_STEPS];
    t_gcd                     gst  [0:GCD_STEPS];
    logic                     dv   [0:DIV_STEPS];
    t_ctx                     dctx [0:DIV_STEPS];
    t_div                     dst  [0:DIV_STEPS];

    logic [COORD_W-1:0]       gcd_val;
    logic [COORD_W-1:0]       qa;
    logic [COORD_W-1:0]       qb;
    logic signed [COORD_W:0]  sgn_a;
    logic signed [COORD_W:0]  sgn_b;
    logic                     flip;
    logic signed [COORD_W+1:0] a_off;
    logic signed [COORD_W+1:0] b_off;
    logic signed [14:0]       sum_p;
    logic signed [13:0]       c_off;

    logic                     r_s_valid;
    logic signed [6:0]        r_s_a;
    logic signed [6:0]        r_s_b;
    logic [COORD_W-1:0]       r_s_x1;
    logic [COORD_W-1:0]       r_s_y1;
    logic                     r_s_oor;

    logic                     r_m1_valid;
    logic signed [6:0]        r_m1_a;
    logic signed [6:0]        r_m1_b;
    logic signed [13:0]       r_m1_pa;
    logic signed [13:0]       r_m1_pb;
    logic [13:0]              r_m1_pk;
    logic [6:0]               r_m1_bo;
    logic                     r_m1_oor;

    logic                     r_m2_valid;
    logic signed [6:0]        r_m2_a;
    logic signed [6:0]        r_m2_b;
    logic signed [12:0]       r_m2_c;
    logic [14:0]              r_m2_k;
    logic                     r_m2_oor;

    logic                     r_m3_valid;
    logic signed [6:0]        r_m3_a;
    logic signed [6:0]        r_m3_b;
    logic signed [12:0]       r_m3_c;
    logic [27:0]              r_m3_prod;
    logic [12:0]              r_m3_coff;
    logic                     r_m3_oor;

    logic                     r_out_valid;
    logic signed [6:0]        r_out_a;
    logic signed [6:0]        r_out_b;
    logic signed [12:0]       r_out_c;
    logic [26:0]              r_out_key;
    logic                     r_out_oor;

    logic                     out_zero;
    logic                     sign_ok;

    // Configuration register and the board constants derived from it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= BOARD_SIDE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BOARD_SIDE) begin
            r_side <= pwdata[SIDE_W-1:0];
        end
        r_coord_off <= COORD_W'(side_eff - SIDE_W'(1));
        r_coord_span <= SIDE_W'({side_eff, 1'b0} - 8'd1);
        r_const_off <= r_coord_off * r_coord_off;
        r_const_span <= {r_const_off, 1'b1};
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BOARD_SIDE) ? {25'd0, r_side} : 32'd0;

    always_comb begin
        if (r_side < SIDE_W'(2)) begin
            side_eff = SIDE_W'(2);
        end else if (r_side > SIDE_W'(MAX_SIDE)) begin
            side_eff = SIDE_W'(MAX_SIDE);
        end else begin
            side_eff = r_side;
        end
    end

    assign en = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Entry: coefficient differences and range check.
    always_comb begin
        diff_a = signed'({1'b0, i_first_y}) - signed'({1'b0, i_second_y});
        diff_b = signed'({1'b0, i_second_x}) - signed'({1'b0, i_first_x});
        n_ctx.x1 = i_first_x;
        n_ctx.y1 = i_first_y;
        n_ctx.sa = diff_a[COORD_W];
        n_ctx.sb = diff_b[COORD_W];
        n_ctx.am = diff_a[COORD_W] ? COORD_W'(-diff_a) : COORD_W'(diff_a);
        n_ctx.bm = diff_b[COORD_W] ? COORD_W'(-diff_b) : COORD_W'(diff_b);
        n_ctx.oor = ({1'b0, i_first_x} >= side_eff) || ({1'b0, i_first_y} >= side_eff)
            || ({1'b0, i_second_x} >= side_eff) || ({1'b0, i_second_y} >= side_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            gv[0] <= 1'b0;
        end else if (en) begin
            gv[0] <= i_valid;
        end
        if (en) begin
            gctx[0] <= n_ctx;
            gst[0].u <= n_ctx.am;
            gst[0].v <= n_ctx.bm;
            gst[0].k <= 3'd0;
        end
    end

    for (genvar gi = 0; gi < GCD_STEPS; gi++) begin : g_gcd
        clk_gcd_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (gv[gi]),
            .i_ctx   (gctx[gi]),
            .i_gcd   (gst[gi]),
            .o_valid (gv[gi+1]),
            .o_ctx   (gctx[gi+1]),
            .o_gcd   (gst[gi+1])
        );
    end

    // The gcd of a and b also divides c, since c = -x1*a - y1*b.
    assign gcd_val = COORD_W'((gst[GCD_STEPS].u | gst[GCD_STEPS].v) << gst[GCD_STEPS].k);

    assign dv[0] = gv[GCD_STEPS];
    assign dctx[0] = gctx[GCD_STEPS];
    assign dst[0].g = gcd_val;
    assign dst[0].na = gctx[GCD_STEPS].am;
    assign dst[0].nb = gctx[GCD_STEPS].bm;
    assign dst[0].ra = '0;
    assign dst[0].rb = '0;

    for (genvar di = 0; di < DIV_STEPS; di++) begin : g_div
        clk_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv[di]),
            .i_ctx   (dctx[di]),
            .i_div   (dst[di]),
            .o_valid (dv[di+1]),
            .o_ctx   (dctx[di+1]),
            .o_div   (dst[di+1])
        );
    end

    // Sign restoration and normalisation.
    always_comb begin
        qa = (dst[DIV_STEPS].g == '0) ? '0 : dst[DIV_STEPS].na;
        qb = (dst[DIV_STEPS].g == '0) ? '0 : dst[DIV_STEPS].nb;
        sgn_a = dctx[DIV_STEPS].sa ? -signed'({1'b0, qa}) : signed'({1'b0, qa});
        sgn_b = dctx[DIV_STEPS].sb ? -signed'({1'b0, qb}) : signed'({1'b0, qb});
        flip = (sgn_a < 0) || (sgn_a == 0 && sgn_b < 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (en) begin
            r_s_valid <= dv[DIV_STEPS];
        end
        if (en) begin
            r_s_a <= flip ? -sgn_a : sgn_a;
            r_s_b <= flip ? -sgn_b : sgn_b;
            r_s_x1 <= dctx[DIV_STEPS].x1;
            r_s_y1 <= dctx[DIV_STEPS].y1;
            r_s_oor <= dctx[DIV_STEPS].oor;
        end
    end

    // Products for the constant term and the first key digit.
    assign a_off = 8'(r_s_a) + signed'({2'b00, r_coord_off});
    assign b_off = 8'(r_s_b) + signed'({2'b00, r_coord_off});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= r_s_valid;
        end
        if (en) begin
            r_m1_a <= r_s_a;
            r_m1_b <= r_s_b;
            r_m1_pa <= signed'({1'b0, r_s_x1}) * r_s_a;
            r_m1_pb <= signed'({1'b0, r_s_y1}) * r_s_b;
            r_m1_pk <= a_off[6:0] * r_coord_span;
            r_m1_bo <= b_off[6:0];
            r_m1_oor <= r_s_oor;
        end
    end

    assign sum_p = 15'(r_m1_pa) + 15'(r_m1_pb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_valid <= 1'b0;
        end else if (en) begin
            r_m2_valid <= r_m1_valid;
        end
        if (en) begin
            r_m2_a <= r_m1_a;
            r_m2_b <= r_m1_b;
            r_m2_c <= 13'(-sum_p);
            r_m2_k <= 15'(r_m1_pk) + 15'(r_m1_bo);
            r_m2_oor <= r_m1_oor;
        end
    end

    assign c_off = 14'(r_m2_c) + signed'({2'b00, r_const_off});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_valid <= 1'b0;
        end else if (en) begin
            r_m3_valid <= r_m2_valid;
        end
        if (en) begin
            r_m3_a <= r_m2_a;
            r_m3_b <= r_m2_b;
            r_m3_c <= r_m2_c;
            r_m3_prod <= 28'(r_m2_k) * 28'(r_const_span);
            r_m3_coff <= c_off[12:0];
            r_m3_oor <= r_m2_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m3_valid;
        end
        if (en) begin
            r_out_a <= r_m3_oor ? '0 : r_m3_a;
            r_out_b <= r_m3_oor ? '0 : r_m3_b;
            r_out_c <= r_m3_oor ? '0 : r_m3_c;
            r_out_key <= r_m3_oor ? '0 : 27'(r_m3_prod + 28'(r_m3_coff));
            r_out_oor <= r_m3_oor;
        end
    end

    assign o_valid = r_out_valid;
    assign o_coef_a = r_out_a;
    assign o_coef_b = r_out_b;
    assign o_coef_c = r_out_c;
    assign o_packed_key = r_out_key;
    assign o_out_of_range = r_out_oor;

    assign out_zero = o_coef_a == 0 && o_coef_b == 0 && o_coef_c == 0 && o_packed_key == 0;
    assign sign_ok = !o_coef_a[6] && (o_coef_a != 0 || !o_coef_b[6]);

    `CLK_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_valid, "pipeline not empty after reset")
    `CLK_ASSERT(a_oor_zero, o_valid && o_out_of_range |-> out_zero, "out of range result not zeroed")
    `CLK_ASSERT(a_sign_norm, o_valid && !o_out_of_range |-> sign_ok, "line signs not normalised")
    `CLK_ASSERT(a_hold, o_valid && i_stall |=> $stable(r_s_a) && $stable(r_m3_prod), "pipeline moved under stall")
endmodule

[tb/canonical_line_key_checker.sv]
// Checker that predicts the canonical line of each point pair and compares the results.
`timescale 1ns / 1ps
module canonical_line_key_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [5:0]         i_first_x,
    input  logic [5:0]         i_first_y,
    input  logic [5:0]         i_second_x,
    input  logic [5:0]         i_second_y,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [6:0]  o_coef_a,
    input  logic signed [6:0]  o_coef_b,
    input  logic signed [12:0] o_coef_c,
    input  logic [26:0]        o_packed_key,
    input  logic               o_out_of_range,
    output int                 o_errors,
    output int                 o_pending
);
    typedef struct packed {
        logic [6:0]  a;
        logic [6:0]  b;
        logic [12:0] c;
        logic [26:0] key;
        logic        oor;
    } t_line;

    t_line      lines_due[$];
    logic [6:0] side_reg;

    function automatic longint gcd_of(longint p, longint q);
        longint r;
        while (q != 0) begin
            r = p % q;
            p = q;
            q = r;
        end
        return p;
    endfunction

    function automatic t_line line_through(logic [6:0] side_raw, int x1, int y1, int x2, int y2);
        t_line  res;
        longint n, a, b, c, g, off, coff, k;
        res = '0;
        n = longint'(side_raw);
        if (n < 2) n = 2;
        if (n > clk_pkg::MAX_SIDE) n = clk_pkg::MAX_SIDE;
        if (x1 >= n || y1 >= n || x2 >= n || y2 >= n) begin
            res.oor = 1'b1;
            return res;
        end
        a = y1 - y2;
        b = x2 - x1;
        c = x1 * y2 - x2 * y1;
        g = gcd_of(gcd_of(a < 0 ? -a : a, b < 0 ? -b : b), c < 0 ? -c : c);
        if (g != 0) begin
            a = a / g;
            b = b / g;
            c = c / g;
        end
        if (a < 0 || (a == 0 && b < 0) || (a == 0 && b == 0 && c < 0)) begin
            a = -a;
            b = -b;
            c = -c;
        end
        off = n - 1;
        coff = off * off;
        k = ((a + off) * (2 * n - 1) + (b + off)) * (2 * coff + 1) + (c + coff);
        res.a = a[6:0];
        res.b = b[6:0];
        res.c = c[12:0];
        res.key = k[26:0];
        return res;
    endfunction

    assign o_pending = lines_due.size();

    always @(posedge i_clk) begin
        t_line want;
        if (!i_rst_n) begin
            side_reg <= clk_pkg::BOARD_SIDE_RESET;
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == clk_pkg::REG_BOARD_SIDE) begin
                side_reg <= pwdata[6:0];
            end
            if (i_valid && !o_stall) begin
                lines_due = {lines_due, line_through(side_reg, int'(i_first_x),
                                                     int'(i_first_y), int'(i_second_x),
                                                     int'(i_second_y))};
            end
            if (o_valid && !i_stall) begin
                if (lines_due.size() == 0) begin
                    $display("%0t: unexpected result transfer a=%0d b=%0d c=%0d key=%0d",
                             $time, o_coef_a, o_coef_b, o_coef_c, o_packed_key);
                    o_errors <= o_errors + 1;
                end else begin
                    want = lines_due.pop_front();
                    if (want.a !== o_coef_a || want.b !== o_coef_b || want.c !== o_coef_c
                        || want.key !== o_packed_key || want.oor !== o_out_of_range) begin
                        $display("%0t: mismatch expected a=%0d b=%0d c=%0d key=%0d oor=%0b",
                                 $time, $signed(want.a), $signed(want.b), $signed(want.c),
                                 want.key, want.oor);
                        $display("%0t:          actual   a=%0d b=%0d c=%0d key=%0d oor=%0b",
                                 $time, o_coef_a, o_coef_b, o_coef_c, o_packed_key,
                                 o_out_of_range);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb.sv]
// Testbench top for the canonical line key block: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb;
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [5:0]         i_first_x = '0, i_first_y = '0, i_second_x = '0, i_second_y = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [6:0]  o_coef_a, o_coef_b;
    logic signed [12:0] o_coef_c;
    logic [26:0]        o_packed_key;
    logic               o_out_of_range;
    int                 errors, pending;
    logic               calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    canonical_line_key_top dut (.*);
    canonical_line_key_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // The receiver stalls in random bursts until the quiet final part of the run.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 17);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_side(logic [6:0] side);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {clk_pkg::REG_BOARD_SIDE, 2'b00};
        pwdata <= {25'd0, side};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // Sends one point pair; the caller is at a falling edge. Valid stays high
    // afterwards until the next gap or drain.
    task automatic send_pair(int x1, int y1, int x2, int y2, bit gaps);
        if (gaps && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_x <= 6'(x1); i_first_y <= 6'(y1); i_second_x <= 6'(x2); i_second_y <= 6'(y2);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_pairs(int count, int side, bit gaps);
        int lim;
        for (int i = 0; i < count; i++) begin
            lim = ($urandom_range(0, 9) == 0) ? 63 : (side > 64 ? 63 : (side < 2 ? 1 : side - 1));
            send_pair($urandom_range(0, lim), $urandom_range(0, lim),
                      $urandom_range(0, lim), $urandom_range(0, lim), gaps);
        end
    endtask

    initial begin
        int sides[6];
        sides = '{28, 2, 64, 0, 127, 37};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_pair(0, 0, 27, 27, 0);
        send_pair(5, 5, 5, 5, 0);
        send_pair(27, 0, 0, 27, 0);
        send_pair(3, 7, 3, 20, 0);
        send_pair(4, 9, 17, 9, 0);
        send_pair(28, 0, 0, 0, 0);
        send_pair(0, 28, 0, 0, 0);
        send_pair(0, 0, 63, 0, 0);
        send_pair(0, 0, 0, 63, 0);
        send_pair(2, 4, 6, 12, 0);
        send_pair(27, 1, 1, 27, 0);
        drain();
        write_side(7'd64);
        send_pair(63, 0, 0, 63, 0);
        send_pair(0, 63, 63, 0, 0);
        send_pair(63, 63, 0, 1, 0);
        send_pair(1, 62, 62, 1, 0);
        send_pair(42, 21, 21, 42, 0);
        send_pair(63, 63, 63, 63, 0);
        drain();
        write_side(7'd2);
        send_pair(0, 0, 1, 1, 0);
        send_pair(1, 0, 0, 1, 0);
        send_pair(2, 0, 0, 0, 0);
        drain();
        foreach (sides[i]) begin
            write_side(7'(sides[i]));
            random_pairs(200, sides[i], 1);
            drain();
        end
        write_side(7'd64);
        random_pairs(100, 64, 1);
        calm = 1'b1;
        random_pairs(150, 64, 0);
        drain();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/clk_pkg.sv
design/clk_gcd_step.sv
design/clk_div_step.sv
design/canonical_line_key_top.sv
tb/canonical_line_key_checker.sv
tb/tb.sv
